// ===== hdl/meov_pkg.sv =====
// ----------------------------------------------------------------------------
// meov_pkg: shared types and constants for the edge adjacency table
// Holds the operation and status codes, the table geometry and the queue
// entry that carries a classified face from front to back.
// ----------------------------------------------------------------------------
package meov_pkg;

  localparam int VertexBits = 20;
  localparam int TableDepth = 4096;
  localparam int IndexBits  = $clog2(TableDepth);
  localparam int KeyBits    = 2 * VertexBits;
  localparam int Corners    = 3;

  typedef logic [VertexBits-1:0] vtx_t;
  typedef logic [KeyBits-1:0]    key_t;
  typedef logic [IndexBits-1:0]  idx_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // One classified face: operation, corner vertices and the opposite-edge keys.
  typedef struct packed {
    op_t  op;
    vtx_t va;
    vtx_t vb;
    vtx_t vc;
    key_t ka;
    key_t kb;
    key_t kc;
  } face_t;

  typedef struct packed {
    logic [VertexBits-1:0] oa;
    logic [VertexBits-1:0] ob;
    logic [VertexBits-1:0] oc;
    logic                  ha;
    logic                  hb;
    logic                  hc;
    status_t               st;
  } result_t;

  function automatic key_t make_key(vtx_t p, vtx_t q);
    if (p < q) return {p, q};
    return {q, p};
  endfunction

endpackage

// ===== hdl/meov_front.sv =====
// ----------------------------------------------------------------------------
// meov_front: face intake and edge key formation
// Accepts a face beat, builds the three opposite-edge keys and pushes the
// classified face into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module meov_front import meov_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      op,
  input  logic [VertexBits-1:0] va,
  input  logic [VertexBits-1:0] vb,
  input  logic [VertexBits-1:0] vc,
  output logic            q_valid,
  input  logic            q_pop,
  output face_t           q_face
);

  face_t     mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;
  logic      push;
  face_t     face_in;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    face_in.op = op_t'(op);
    face_in.va = va;
    face_in.vb = vb;
    face_in.vc = vc;
    face_in.ka = make_key(vb, vc);
    face_in.kb = make_key(vc, va);
    face_in.kc = make_key(va, vb);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= face_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_face  = mem[rd_ptr];

endmodule

// ===== hdl/meov_hash.sv =====
// ----------------------------------------------------------------------------
// meov_hash: registered multiplicative hash of an edge key
// Key times the golden-ratio constant mod 2^64, split into 32-bit partial
// products that are registered and then summed; bits 63..32 modulo the depth.
// ----------------------------------------------------------------------------
module meov_hash import meov_pkg::*; (
  input  logic clk,
  input  key_t key,
  output idx_t idx
);

  localparam logic [63:0] Golden = 64'h9E3779B97F4A7C15;

  logic [63:0] k64;
  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [31:0] hi;

  assign k64 = {{(64-KeyBits){1'b0}}, key};

  always_ff @(posedge clk) begin
    p_ll <= {32'd0, k64[31:0]} * {32'd0, Golden[31:0]};
    p_lh <= k64[31:0] * Golden[63:32];
    p_hl <= k64[63:32] * Golden[31:0];
  end

  assign hi  = p_ll[63:32] + p_lh + p_hl;
  assign idx = hi[IndexBits-1:0];

endmodule

// ===== hdl/meov_back.sv =====
// ----------------------------------------------------------------------------
// meov_back: probe sequencer over the edge table
// Hashes each corner key, walks the table by linear probing with a
// registered read per probe, updates entries on insert, gathers opposites on
// query and sweeps the used bits on clear.
// ----------------------------------------------------------------------------
module meov_back import meov_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_pop,
  input  face_t   q_face,
  output logic    res_valid,
  input  logic    res_take,
  output result_t res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_HWAIT = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam int EntryBits = KeyBits + 2 * VertexBits + 2;

  state_t state;
  face_t  face;
  logic [1:0] corner;
  key_t   key;
  vtx_t   vtx;
  idx_t   hidx;
  idx_t   idx;
  logic [IndexBits:0] probes;
  result_t acc;
  logic   boot;

  logic                  used_mem [TableDepth];
  logic [EntryBits-1:0]  tbl [TableDepth];
  logic [EntryBits-1:0]  rd;
  logic                  rd_used;
  logic                  wr_en;
  logic [EntryBits-1:0]  wr_data;
  logic                  used_we;
  logic                  used_wd;

  key_t rk;
  vtx_t s1;
  vtx_t s2;
  logic s2v;

  meov_hash u_hash (.clk(clk), .key(key), .idx(hidx));

  always_comb begin
    unique case (corner)
      2'd0:    begin key = face.ka; vtx = face.va; end
      2'd1:    begin key = face.kb; vtx = face.vb; end
      default: begin key = face.kc; vtx = face.vc; end
    endcase
  end

  assign rk  = rd[EntryBits-1 -: KeyBits];
  assign s2v = rd[2*VertexBits+1];
  assign s2  = rd[2*VertexBits-1:VertexBits];
  assign s1  = rd[VertexBits-1:0];

  // used bits live in their own RAM; clear walks it one entry a cycle
  assign used_we = (state == S_CLEAR) || (wr_en && !rd_used);
  assign used_wd = (state != S_CLEAR);

  always_ff @(posedge clk) begin
    rd      <= tbl[idx];
    rd_used <= used_mem[idx];
    if (wr_en) tbl[idx] <= wr_data;
    if (used_we) used_mem[idx] <= used_wd;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = {key, s2, s1, 1'b1, rd[2*VertexBits]};
    if (state == S_CHECK && face.op == OP_INSERT) begin
      if (rd_used && rk == key) begin
        wr_en   = 1'b1;
        wr_data = {key, 1'b1, rd[2*VertexBits], vtx, s1};
      end else if (!rd_used) begin
        wr_en   = 1'b1;
        wr_data = {key, 1'b0, 1'b1, {VertexBits{1'b0}}, vtx};
      end
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_DONE);
  assign res       = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      boot   <= 1'b1;
      corner <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            face   <= q_face;
            corner <= 2'd0;
            acc    <= '0;
            idx    <= '0;
            unique case (q_face.op)
              OP_INSERT, OP_QUERY: state <= S_HASH;
              OP_CLEAR:            state <= S_CLEAR;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_HASH:  state <= S_HWAIT;
        S_HWAIT: begin
          idx    <= hidx;
          probes <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_used && rk != key) begin
            if (probes == (IndexBits+1)'(TableDepth - 1)) begin
              if (face.op == OP_INSERT) acc.st <= ST_FULL;
              else acc.st <= ST_NOTFOUND;
              corner <= corner + 2'd1;
              state  <= (corner == 2'd2) ? S_DONE : S_HASH;
            end else begin
              probes <= probes + 1'b1;
              idx    <= idx + 1'b1;
              state  <= S_READ;
            end
          end else begin
            if (face.op == OP_INSERT) begin
            end else if (!rd_used) begin
              acc.st <= ST_NOTFOUND;
            end else begin
              unique case (corner)
                2'd0: begin
                  acc.oa <= (s1 == vtx) ? (s2v ? s2 : '0) : s1;
                  acc.ha <= (s1 != vtx) || s2v;
                end
                2'd1: begin
                  acc.ob <= (s1 == vtx) ? (s2v ? s2 : '0) : s1;
                  acc.hb <= (s1 != vtx) || s2v;
                end
                default: begin
                  acc.oc <= (s1 == vtx) ? (s2v ? s2 : '0) : s1;
                  acc.hc <= (s1 != vtx) || s2v;
                end
              endcase
            end
            corner <= corner + 2'd1;
            state  <= (corner == 2'd2) ? S_DONE : S_HASH;
          end
        end
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == '1) begin
            state <= boot ? S_IDLE : S_DONE;
            boot  <= 1'b0;
          end
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/meov_out.sv =====
// ----------------------------------------------------------------------------
// meov_out: result skid register
// Holds one finished result beat so the sequencer can start the next face
// while the consumer stalls.
// ----------------------------------------------------------------------------
module meov_out import meov_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  output logic    res_take,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res <= res;
  end

endmodule

// ===== hdl/mesh_edge_opposite_vertex.sv =====
// ----------------------------------------------------------------------------
// mesh_edge_opposite_vertex: triangle mesh edge adjacency table
// Insert, query and clear faces against a 4096-entry hashed edge table.
// ----------------------------------------------------------------------------
// Each face beat gives one result beat. An insert or query hashes each corner
// key and walks the table past each collision, the single-ported table read
// setting the pace of the probe loop; a clear sweeps the used bits one entry a
// cycle. After reset the same sweep runs before the first face is started. A
// two-deep queue accepts faces while the back end works and a result register
// holds the answer while the output stalls.
module mesh_edge_opposite_vertex import meov_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [VertexBits-1:0] vertex_a,
  input  logic [VertexBits-1:0] vertex_b,
  input  logic [VertexBits-1:0] vertex_c,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VertexBits-1:0] opposite_a,
  output logic [VertexBits-1:0] opposite_b,
  output logic [VertexBits-1:0] opposite_c,
  output logic                  has_opposite_a,
  output logic                  has_opposite_b,
  output logic                  has_opposite_c,
  output logic [1:0]            status
);

  logic    q_valid;
  logic    q_pop;
  face_t   q_face;
  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_res;

  meov_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(operation), .va(vertex_a), .vb(vertex_b), .vc(vertex_c),
    .q_valid(q_valid), .q_pop(q_pop), .q_face(q_face)
  );

  meov_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_face(q_face),
    .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  meov_out u_out (
    .clk(clk), .rst(rst), .res_valid(res_valid), .res_take(res_take),
    .res(res), .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res)
  );

  assign opposite_a     = out_res.oa;
  assign opposite_b     = out_res.ob;
  assign opposite_c     = out_res.oc;
  assign has_opposite_a = out_res.ha;
  assign has_opposite_b = out_res.hb;
  assign has_opposite_c = out_res.hc;
  assign status         = out_res.st;

`ifndef ASSERT_OFF
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue pop while empty");

  a_take_needs_res: assert property (@(posedge clk) disable iff (rst)
    res_take |-> res_valid) else $error("result taken while none ready");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !q_pop) else $error("new face started before result left");

  a_boundary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_opposite_a) |-> (opposite_a == '0))
    else $error("boundary corner with nonzero opposite");
`endif

endmodule
